// ===== src/caldn_pkg.sv =====
// ----------------------------------------------------------------------------
// caldn_pkg
// Shared types, field layout and calendar tables for the date converter.
// ----------------------------------------------------------------------------
`default_nettype none

package caldn_pkg;

   typedef enum logic [3:0] {
      ST_OK       = 4'd0,
      ST_YEAR     = 4'd1,
      ST_MONTH    = 4'd2,
      ST_DAY      = 4'd3,
      ST_YDAY     = 4'd4,
      ST_FEB29    = 4'd5,
      ST_YDAY366  = 4'd6,
      ST_HOUR     = 4'd7,
      ST_MINUTE   = 4'd8,
      ST_SECOND   = 4'd9
   } status_type;

   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 80;

   localparam logic [11:0] YEAR_MIN      = 12'd1900;
   localparam logic [11:0] YEAR_MAX      = 12'd2400;
   localparam logic [8:0]  YDAY_MAX      = 9'd366;
   localparam logic [25:0] SECOND_US_MAX = 26'd59999999;
   localparam logic [18:0] EPOCH_OFFSET  = 19'd36524;

   // first day of year of each month, leap year layout
   function automatic logic [8:0] month_start(input logic [3:0] mi);
      logic [8:0] s;
      case (mi)
         4'd0:    s = 9'd1;
         4'd1:    s = 9'd32;
         4'd2:    s = 9'd61;
         4'd3:    s = 9'd92;
         4'd4:    s = 9'd122;
         4'd5:    s = 9'd153;
         4'd6:    s = 9'd183;
         4'd7:    s = 9'd214;
         4'd8:    s = 9'd245;
         4'd9:    s = 9'd275;
         4'd10:   s = 9'd306;
         4'd11:   s = 9'd336;
         default: s = 9'd1;
      endcase
      return s;
   endfunction

   function automatic logic [8:0] start_of(input logic [3:0] mi, input logic leap);
      logic [8:0] s;
      s = month_start(mi);
      if (!leap && mi > 4'd1) begin
         s = s - 9'd1;
      end
      return s;
   endfunction

   // longest length of each month (Feb 29 allowed)
   function automatic logic [4:0] month_len(input logic [3:0] mi);
      logic [4:0] n;
      case (mi)
         4'd1:    n = 5'd29;
         4'd3,
         4'd5,
         4'd8,
         4'd10:   n = 5'd30;
         default: n = 5'd31;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== src/calendar_date_to_day_number.sv =====
// ----------------------------------------------------------------------------
// calendar_date_to_day_number
// Gregorian date check and conversion to day of year, day number and
// time of day in microseconds.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one parsed date per item. req_tuser selects the date form
//   (year/month/day or year/day of year) and whether the time fields count.
//   rsp channel: one result per item, in order: status, leap flag, month,
//   day, day of year, day number (Jan 1 2000 = 1, signed) and microseconds
//   since midnight. All fields except status are zero on a failed check.
//   Path: an accepted item goes into the input register and is offered on
//   rsp from the result register once it has been converted.
//   Throughput: one item per cycle while rsp_tready stays high; the input
//   register and the result register each hold one item, and conversion
//   is a single pass of logic between them.
//   Stall: while rsp_tready is low the result register holds its item; the
//   input register still takes one more item, then req_tready drops until
//   the result is taken.
//   Reset: synchronous, clears both stage valids; nothing is offered and
//   items are accepted in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_to_day_number
   import caldn_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // year[11:0] month[15:12] day[20:16] year_day[29:21] hour[35:30]
   // minute[41:36] second_us[67:42], zero pad[71:68]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // day_of_year_mode[0] with_time[1]
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // status[3:0] is_leap[4] out_month[8:5] out_day[13:9] out_year_day[22:14]
   // day_number[41:23] seconds_of_day_us[78:42], zero pad[79]
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   logic                  a_valid_ff, a_valid_in;
   logic [REQ_DATA_W-1:0] a_data_ff;
   logic [REQ_USER_W-1:0] a_user_ff;
   logic                  b_valid_ff, b_valid_in;
   logic [RSP_DATA_W-1:0] b_data_ff, b_data_in;
   logic                  b_load;

   assign b_load     = a_valid_ff && (!b_valid_ff || rsp_tready);
   assign req_tready = !a_valid_ff || b_load;
   assign a_valid_in = (req_tvalid && req_tready) || (a_valid_ff && !b_load);
   assign b_valid_in = b_load || (b_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         a_data_ff <= req_tdata;
         a_user_ff <= req_tuser;
      end
      if (b_load) begin
         b_data_ff <= b_data_in;
      end
   end

   assign rsp_tvalid = b_valid_ff;
   assign rsp_tdata  = b_data_ff;

   // conversion
   logic        yd_mode, timed, leap;
   logic [11:0] year;
   logic [3:0]  month, mon_out;
   logic [4:0]  day, day_out;
   logic [8:0]  yday, doy, y1, jleap, start;
   logic [5:0]  hour, minute;
   logic [25:0] sec_us;
   logic [1:0]  corr;
   logic [17:0] dn_sum;
   logic [18:0] dn;
   logic [36:0] us;
   status_type  status;

   assign yd_mode = a_user_ff[0];
   assign timed   = a_user_ff[1];
   assign year    = a_data_ff[11:0];
   assign month   = a_data_ff[15:12];
   assign day     = a_data_ff[20:16];
   assign yday    = a_data_ff[29:21];
   assign hour    = timed ? a_data_ff[35:30] : 6'd0;
   assign minute  = timed ? a_data_ff[41:36] : 6'd0;
   assign sec_us  = timed ? a_data_ff[67:42] : 26'd0;

   assign leap = (year[1:0] == 2'd0) && (year != 12'd1900) && (year != 12'd2100)
              && (year != 12'd2200) && (year != 12'd2300);

   always_comb begin
      mon_out = 4'd0;
      if (yd_mode) begin
         doy = yday;
         for (int mi = 0; mi < 12; mi++) begin
            if (doy >= start_of(4'(mi), leap)) begin
               mon_out = 4'(mi + 1);
            end
         end
         start   = start_of(mon_out - 4'd1, leap);
         day_out = 5'(doy - start + 9'd1);
      end else begin
         mon_out = month;
         day_out = day;
         start   = start_of(month - 4'd1, leap);
         doy     = 9'(day) + start - 9'd1;
      end
   end

   always_comb begin
      y1 = 9'(year - YEAR_MIN);
      if (year >= 12'd2301) begin
         corr = 2'd3;
      end else if (year >= 12'd2201) begin
         corr = 2'd2;
      end else if (year >= 12'd2101) begin
         corr = 2'd1;
      end else begin
         corr = 2'd0;
      end
      jleap = 9'd0;
      if (y1 != 9'd0) begin
         jleap = ((y1 - 9'd1) >> 2) - 9'(corr);
      end
      dn_sum = 18'(y1) * 18'd365 + 18'(jleap) + 18'(doy);
      dn     = {1'b0, dn_sum} - EPOCH_OFFSET;
   end

   assign us = 37'(hour) * 37'd3600000000 + 37'(minute) * 37'd60000000 + 37'(sec_us);

   always_comb begin
      status = ST_OK;
      if (year < YEAR_MIN || year > YEAR_MAX) begin
         status = ST_YEAR;
      end else if (!yd_mode && (month < 4'd1 || month > 4'd12)) begin
         status = ST_MONTH;
      end else if (!yd_mode && (day < 5'd1 || day > month_len(month - 4'd1))) begin
         status = ST_DAY;
      end else if (yd_mode && (yday < 9'd1 || yday > YDAY_MAX)) begin
         status = ST_YDAY;
      end else if (!yd_mode && month == 4'd2 && !leap && day > 5'd28) begin
         status = ST_FEB29;
      end else if (yd_mode && !leap && yday == YDAY_MAX) begin
         status = ST_YDAY366;
      end else if (hour > 6'd23) begin
         status = ST_HOUR;
      end else if (minute > 6'd59) begin
         status = ST_MINUTE;
      end else if (sec_us > SECOND_US_MAX) begin
         status = ST_SECOND;
      end
   end

   always_comb begin
      if (status == ST_OK) begin
         b_data_in = {1'b0, us, dn, doy, day_out, mon_out, leap, status};
      end else begin
         b_data_in = {{(RSP_DATA_W-4){1'b0}}, status};
      end
   end

`ifndef SYNTHESIS
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3:0] != ST_OK |-> rsp_tdata[RSP_DATA_W-1:4] == '0)
      else $error("failed item carries nonzero fields");

   a_ok_month: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3:0] == ST_OK |->
         rsp_tdata[8:5] >= 4'd1 && rsp_tdata[8:5] <= 4'd12 && rsp_tdata[13:9] != 5'd0)
      else $error("valid date with bad month or day");

   a_ok_yday: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3:0] == ST_OK && !rsp_tdata[4] |->
         rsp_tdata[22:14] >= 9'd1 && rsp_tdata[22:14] <= 9'd365)
      else $error("common year day of year out of range");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      b_load |=> rsp_tvalid)
      else $error("item moved to result stage but not offered");
`endif

endmodule

`default_nettype wire

// ===== sim/calendar_date_to_day_number_checker.sv =====
// ----------------------------------------------------------------------------
// calendar_date_to_day_number_checker
// Watches both streams of the date converter, computes the expected result
// of every accepted item, and compares each returned result field by field
// against the oldest one outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module calendar_date_to_day_number_checker
   import caldn_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   // year[11:0] month[15:12] day[20:16] year_day[29:21] hour[35:30]
   // minute[41:36] second_us[67:42], zero pad[71:68]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // day_of_year_mode[0] with_time[1]
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // status[3:0] is_leap[4] out_month[8:5] out_day[13:9] out_year_day[22:14]
   // day_number[41:23] seconds_of_day_us[78:42], zero pad[79]
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                         mismatch_count,
   output int                         dates_pending
);

   localparam int FIRST_YEAR  = 1900;
   localparam int LAST_YEAR   = 2400;
   localparam int EPOCH_SHIFT = 36524;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      status_type  status;
      logic        leap;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [8:0]  yday;
      logic [18:0] day_number;
      logic [36:0] sod_us;
   } date_result_type;

   date_result_type expected_dates [$];
   int              failures = 0;

   // first day of year of month index mi
   function automatic int month_first_day(input int mi, input bit leap);
      int s;
      case (mi)
         0:       s = 1;
         1:       s = 32;
         2:       s = 61;
         3:       s = 92;
         4:       s = 122;
         5:       s = 153;
         6:       s = 183;
         7:       s = 214;
         8:       s = 245;
         9:       s = 275;
         10:      s = 306;
         default: s = 336;
      endcase
      if (!leap && mi > 1) begin
         s = s - 1;
      end
      return s;
   endfunction

   function automatic date_result_type convert_date(input logic [REQ_USER_W-1:0] user,
                                                    input logic [REQ_DATA_W-1:0] data);
      date_result_type r;
      bit              yd_mode;
      bit              timed;
      bit              leap;
      int              year;
      int              month;
      int              day;
      int              yday;
      int              doy;
      int              max_day;
      int              y1;
      int              leap_days;
      int              m;
      longint          hour;
      longint          minute;
      longint          sec_us;
      r       = '0;
      yd_mode = user[0];
      timed   = user[1];
      year    = data[11:0];
      month   = data[15:12];
      day     = data[20:16];
      yday    = data[29:21];
      hour    = data[35:30];
      minute  = data[41:36];
      sec_us  = data[67:42];

      if (year < FIRST_YEAR || year > LAST_YEAR) begin
         r.status = ST_YEAR;
         return r;
      end
      if (!yd_mode) begin
         if (month < 1 || month > 12) begin
            r.status = ST_MONTH;
            return r;
         end
         case (month)
            2:           max_day = 29;
            4, 6, 9, 11: max_day = 30;
            default:     max_day = 31;
         endcase
         if (day < 1 || day > max_day) begin
            r.status = ST_DAY;
            return r;
         end
      end else if (yday < 1 || yday > 366) begin
         r.status = ST_YDAY;
         return r;
      end

      leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));

      if (!yd_mode) begin
         if (month == 2 && !leap && day > 28) begin
            r.status = ST_FEB29;
            return r;
         end
         doy = day + month_first_day(month - 1, leap) - 1;
      end else begin
         if (!leap && yday > 365) begin
            r.status = ST_YDAY366;
            return r;
         end
         doy   = yday;
         month = 0;
         for (m = 0; m < 12; m++) begin
            if (doy >= month_first_day(m, leap)) begin
               month = m + 1;
            end
         end
         day = doy - month_first_day(month - 1, leap) + 1;
      end

      // leap days in the whole years since 1900 (1900 itself is common)
      y1        = year - FIRST_YEAR;
      leap_days = 0;
      if (y1 > 0) begin
         leap_days = (y1 - 1) / 4;
         if (year > 2100) begin
            leap_days = leap_days - (year - 2001) / 100;
         end
      end

      if (!timed) begin
         hour   = 0;
         minute = 0;
         sec_us = 0;
      end
      if (hour > 23) begin
         r.status = ST_HOUR;
         return r;
      end
      if (minute > 59) begin
         r.status = ST_MINUTE;
         return r;
      end
      if (sec_us > 64'd59999999) begin
         r.status = ST_SECOND;
         return r;
      end

      r.status     = ST_OK;
      r.leap       = leap;
      r.month      = month[3:0];
      r.day        = day[4:0];
      r.yday       = doy[8:0];
      r.day_number = 19'(y1 * 365 + leap_days + doy - EPOCH_SHIFT);
      r.sod_us     = 37'((hour * 60 + minute) * 60 * 1000000 + sec_us);
      return r;
   endfunction

   always @(posedge clock) begin
      date_result_type got;
      date_result_type want;
      if (reset) begin
         expected_dates.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            expected_dates.push_back(convert_date(req_tuser, req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status     = status_type'(rsp_tdata[3:0]);
            got.leap       = rsp_tdata[4];
            got.month      = rsp_tdata[8:5];
            got.day        = rsp_tdata[13:9];
            got.yday       = rsp_tdata[22:14];
            got.day_number = rsp_tdata[41:23];
            got.sod_us     = rsp_tdata[78:42];
            if (expected_dates.size() == 0) begin
               failures++;
               if (failures <= REPORT_MAX) begin
                  $display("%0t: result with no item outstanding: status %0d", $realtime,
                           got.status);
               end
            end else begin
               want = expected_dates.pop_front();
               if (got.status != want.status || got.leap != want.leap ||
                   got.month != want.month || got.day != want.day ||
                   got.yday != want.yday || got.day_number != want.day_number ||
                   got.sod_us != want.sod_us) begin
                  failures++;
                  if (failures <= REPORT_MAX) begin
                     $display("%0t: mismatch (exp/got) status %0d/%0d leap %0d/%0d month %0d/%0d",
                              $realtime, want.status, got.status, want.leap, got.leap,
                              want.month, got.month);
                     $display("   day %0d/%0d yday %0d/%0d day_number %0d/%0d sod_us %0d/%0d",
                              want.day, got.day, want.yday, got.yday,
                              $signed(want.day_number), $signed(got.day_number),
                              want.sod_us, got.sod_us);
                  end
               end
            end
         end
      end
      mismatch_count <= failures;
      dates_pending  <= expected_dates.size();
   end

endmodule

// ===== sim/calendar_date_to_day_number_test.sv =====
// ----------------------------------------------------------------------------
// calendar_date_to_day_number_test
// Drives directed dates, then random dates under four flow control mixes,
// into the converter; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module calendar_date_to_day_number_test
   import caldn_pkg::*;
();

   localparam int STALL_LIMIT   = 1000;
   localparam int DATES_PER_MIX = 225;
   localparam int TAIL_CYCLES   = 10;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   // year[11:0] month[15:12] day[20:16] year_day[29:21] hour[35:30]
   // minute[41:36] second_us[67:42], zero pad[71:68]
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // day_of_year_mode[0] with_time[1]
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tready = 1'b0;
   wire                   req_tready;
   wire                   rsp_tvalid;
   // status[3:0] is_leap[4] out_month[8:5] out_day[13:9] out_year_day[22:14]
   // day_number[41:23] seconds_of_day_us[78:42], zero pad[79]
   wire [RSP_DATA_W-1:0]  rsp_tdata;

   int mismatch_count;
   int dates_pending;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int quiet_cycles       = 0;
   int mix;

   always #10 clock = ~clock;

   calendar_date_to_day_number dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   calendar_date_to_day_number_checker date_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .dates_pending  (dates_pending)
   );

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_date(input bit yd_mode, input bit timed, input int year,
                            input int month, input int day, input int yday,
                            input int hour, input int minute, input int sec_us);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {timed, yd_mode};
      req_tdata  <= {4'b0, sec_us[25:0], minute[5:0], hour[5:0], yday[8:0], day[4:0],
                     month[3:0], year[11:0]};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   task automatic send_random_date();
      bit yd_mode;
      bit timed;
      int year;
      int month;
      int day;
      int yday;
      int hour;
      int minute;
      int sec_us;
      int max_day;
      yd_mode = $urandom_range(1);
      timed   = ($urandom_range(3) != 0);

      case ($urandom_range(15))
         0:       year = $urandom_range(4095);
         1:       year = 1900 + 100 * $urandom_range(5);
         2, 3:    year = 1904 + 4 * $urandom_range(124);
         default: year = $urandom_range(2400, 1900);
      endcase

      if ($urandom_range(15) == 0) begin
         month = $urandom_range(15);
      end else begin
         month = $urandom_range(12, 1);
      end
      case (month)
         2:           max_day = 29;
         4, 6, 9, 11: max_day = 30;
         default:     max_day = 31;
      endcase
      case ($urandom_range(15))
         0:       day = $urandom_range(31);
         1, 2, 3: day = max_day;
         default: day = $urandom_range(max_day, 1);
      endcase

      case ($urandom_range(15))
         0:       yday = $urandom_range(511);
         1, 2, 3: yday = $urandom_range(366, 360);
         default: yday = $urandom_range(366, 1);
      endcase

      hour   = ($urandom_range(15) == 0) ? $urandom_range(63) : $urandom_range(23);
      minute = ($urandom_range(15) == 0) ? $urandom_range(63) : $urandom_range(59);
      sec_us = ($urandom_range(15) == 0) ? $urandom_range(67108863) : $urandom_range(59999999);

      send_date(yd_mode, timed, year, month, day, yday, hour, minute, sec_us);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // year range and the all-ones / zero field values
      send_date(0, 1, 1900, 1, 1, 0, 0, 0, 0);
      send_date(0, 1, 2400, 12, 31, 511, 23, 59, 59999999);
      send_date(0, 0, 1899, 1, 1, 1, 0, 0, 0);
      send_date(0, 0, 2401, 1, 1, 1, 0, 0, 0);
      send_date(1, 1, 0, 0, 0, 0, 0, 0, 0);
      send_date(1, 1, 4095, 15, 31, 511, 63, 63, 67108863);
      // month and day limits
      send_date(0, 0, 2000, 0, 1, 1, 0, 0, 0);
      send_date(0, 0, 2000, 13, 1, 1, 0, 0, 0);
      send_date(0, 0, 2000, 15, 31, 1, 0, 0, 0);
      send_date(0, 0, 2000, 4, 0, 1, 0, 0, 0);
      send_date(0, 0, 2000, 4, 31, 1, 0, 0, 0);
      send_date(0, 0, 2000, 2, 30, 1, 0, 0, 0);
      // Feb 29 against the leap rule
      send_date(0, 0, 2000, 2, 29, 1, 0, 0, 0);
      send_date(0, 0, 1900, 2, 29, 1, 0, 0, 0);
      send_date(0, 0, 2001, 2, 29, 1, 0, 0, 0);
      send_date(0, 1, 2100, 3, 1, 1, 12, 30, 30000000);
      // day of year limits, day 366, garbage in unused fields
      send_date(1, 0, 2000, 0, 0, 0, 0, 0, 0);
      send_date(1, 0, 2000, 15, 31, 367, 0, 0, 0);
      send_date(1, 0, 2001, 0, 0, 366, 0, 0, 0);
      send_date(1, 1, 2000, 13, 0, 366, 23, 59, 59999999);
      send_date(1, 0, 2400, 0, 0, 60, 0, 0, 0);
      // time limits; bad time ignored when untimed
      send_date(0, 1, 2024, 6, 15, 1, 24, 0, 0);
      send_date(0, 1, 2024, 6, 15, 1, 0, 60, 0);
      send_date(0, 1, 2024, 6, 15, 1, 0, 0, 60000000);
      send_date(0, 0, 2024, 6, 15, 1, 63, 63, 67108863);

      for (mix = 0; mix < 4; mix++) begin
         case (mix)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 58;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 58;
            end
            default: begin
               sender_idle_pct    = 12;
               receiver_stall_pct = 12;
            end
         endcase
         repeat (DATES_PER_MIX) send_random_date();
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (dates_pending != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && dates_pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== calendar_date_to_day_number.f =====
src/caldn_pkg.sv
src/calendar_date_to_day_number.sv
sim/calendar_date_to_day_number_checker.sv
sim/calendar_date_to_day_number_test.sv
